>>> hdl/mfa_pkg.sv
// Shared constants, word types and sequencer codes for the matched filter accumulator.
`timescale 1ns / 1ps

package mfa_pkg;

  localparam int unsigned MaxGates = 1024;
  localparam int unsigned GateW    = $clog2(MaxGates);
  localparam int unsigned CountW   = 11;
  localparam int unsigned AccW     = 48;
  localparam int unsigned InfoW    = 47;
  localparam int unsigned SampW    = 16;
  localparam int unsigned VarW     = 16;
  localparam int unsigned ProdW    = 2 * SampW;
  localparam int unsigned SumW     = ProdW + 1;
  localparam int unsigned QuoW     = ProdW;
  localparam int unsigned RemW     = VarW + 1;
  localparam int unsigned StepW    = $clog2(QuoW);
  localparam int unsigned MemW     = 3 * AccW;

  typedef enum logic [3:0] {
    MfaIdle,
    MfaRead,
    MfaLoad,
    MfaMulA,
    MfaMulB,
    MfaSum,
    MfaDiv,
    MfaAcc,
    MfaWrite
  } mfa_state_e;

  typedef enum logic [1:0] {
    OpInfo,
    OpYre,
    OpYim
  } mfa_op_e;

  typedef enum logic {
    KindAccum = 1'b0,
    KindClear = 1'b1
  } mfa_kind_e;

  typedef struct packed {
    logic                     kind;
    logic signed [SampW-1:0]  a_re;
    logic signed [SampW-1:0]  a_im;
    logic                     nonzero;
    logic signed [SampW-1:0]  meas_re;
    logic signed [SampW-1:0]  meas_im;
    logic        [VarW-1:0]   variance;
  } mfa_in_t;

  typedef struct packed {
    logic        [GateW-1:0]  gate_index;
    logic        [InfoW-1:0]  info_sum;
    logic signed [AccW-1:0]   y_re;
    logic signed [AccW-1:0]   y_im;
    logic                     last_of_row;
    logic                     div_error;
  } mfa_out_t;

endpackage

>>> hdl/matched_filter_accumulate_core.sv
// Matched filter accumulator: per-gate information and y sums, one shared multiplier and divider.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel in_valid_i / in_ready_o / in_word_i takes one word per item: an
//   accumulate word adds |a|^2/v (when nonzero) and conj(a)*m/v to the gate at the
//   internal counter; a clear word zeroes that gate. Every item returns one word on
//   out_valid_o / out_ready_i / out_word_o with the gate's sums after the update.
//   cfg_we_i / cfg_data_i write gate_count; the user must do so only while the block
//   is idle, as the block itself has no check for this.
// Sequence: a clear word or a zero variance reads the gate and writes it back; an
//   accumulate word works out three quotients, or two when nonzero is clear. Each takes
//   two passes through the shared 16x16 multiplier, one sum, 32 steps of the radix-2
//   divider and one saturating add.
// Flow: one item at a time; in_ready_o is high only while the sequencer idles, so a
//   new item is taken only after the last one has left the write state.
// Reset: counter and sums read as zero, gate_count is 1024. A fill mark tracks
//   which gates were written since reset, so no clearing pass is needed.
// Stall: a finished word waits in the output register; the next item is accepted
//   and worked on, and its result holds in the write state until the register frees.
module matched_filter_accumulate_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  mfa_pkg::mfa_in_t        in_word_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output mfa_pkg::mfa_out_t       out_word_o,
  input  logic                    cfg_we_i,
  input  logic [mfa_pkg::CountW-1:0] cfg_data_i
);

  import mfa_pkg::*;

  mfa_state_e state_q, state_d;
  mfa_op_e    op_q, op_d;

  logic [CountW-1:0] gate_count_q;
  logic [GateW-1:0]  counter_q;
  logic [CountW-1:0] fill_q;

  mfa_in_t           in_q;
  logic [GateW-1:0]  idx_q;
  logic              last_q;
  logic              err_q;

  logic signed [AccW-1:0] info_q, yre_q, yim_q;
  logic [MemW-1:0]        mem [MaxGates];
  logic [MemW-1:0]        rd_q;
  logic                   mem_we;

  logic signed [ProdW-1:0] prod_q, first_q;
  logic [RemW-1:0]         div_rem_q;
  logic [QuoW-1:0]         div_quo_q;
  logic [StepW-1:0]        div_cnt_q;
  logic                    div_neg_q;

  logic                    out_valid_q;
  mfa_out_t                out_q;

  logic                    in_fire;
  logic                    out_free;
  logic [CountW-1:0]       gc_eff;
  logic [GateW-1:0]        idx_sel;
  logic [CountW-1:0]       idx_inc;
  logic                    rd_valid;

  logic signed [SampW-1:0] mul_x, mul_y;
  logic signed [ProdW-1:0] mul_p;
  logic signed [SumW-1:0]  sum_w;
  logic [SumW-1:0]         mag_w;
  logic [RemW-1:0]         div_sh;
  logic                    div_ge;
  logic signed [SumW-1:0]  quo_s;
  logic signed [AccW-1:0]  acc_sel;
  logic signed [AccW:0]    acc_sum;
  logic signed [AccW-1:0]  acc_sat;
  logic [CountW-1:0]       idx_q_inc;

  assign in_ready_o = (state_q == MfaIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign gc_eff   = (gate_count_q == '0 || gate_count_q > CountW'(MaxGates)) ?
                    CountW'(MaxGates) : gate_count_q;
  assign idx_sel  = ({1'b0, counter_q} < gc_eff) ? counter_q : '0;
  assign idx_inc  = {1'b0, idx_sel} + CountW'(1);
  assign rd_valid = ({1'b0, idx_q} < fill_q);
  assign idx_q_inc = {1'b0, idx_q} + CountW'(1);

  always_comb begin
    mul_x = (state_q == MfaMulB) ? in_q.a_im : in_q.a_re;
    case (op_q)
      OpInfo:  mul_y = (state_q == MfaMulB) ? in_q.a_im : in_q.a_re;
      OpYre:   mul_y = (state_q == MfaMulB) ? in_q.meas_im : in_q.meas_re;
      OpYim:   mul_y = (state_q == MfaMulB) ? in_q.meas_re : in_q.meas_im;
      default: mul_y = in_q.a_re;
    endcase
  end
  assign mul_p = mul_x * mul_y;

  assign sum_w = (op_q == OpYim) ?
                 SumW'({first_q[ProdW-1], first_q} - {prod_q[ProdW-1], prod_q}) :
                 SumW'({first_q[ProdW-1], first_q} + {prod_q[ProdW-1], prod_q});
  assign mag_w = sum_w[SumW-1] ? SumW'(-sum_w) : SumW'(sum_w);

  assign div_sh = {div_rem_q[RemW-2:0], div_quo_q[QuoW-1]};
  assign div_ge = (div_sh >= {1'b0, in_q.variance});

  assign quo_s = div_neg_q ? SumW'(-$signed({1'b0, div_quo_q})) :
                             $signed({1'b0, div_quo_q});

  always_comb begin
    case (op_q)
      OpInfo:  acc_sel = info_q;
      OpYre:   acc_sel = yre_q;
      OpYim:   acc_sel = yim_q;
      default: acc_sel = yre_q;
    endcase
  end
  assign acc_sum = {acc_sel[AccW-1], acc_sel} +
                   {{(AccW+1-SumW){quo_s[SumW-1]}}, quo_s};
  always_comb begin
    if (acc_sum[AccW] != acc_sum[AccW-1]) begin
      acc_sat = acc_sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[AccW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    mem_we  = 1'b0;
    case (state_q)
      MfaIdle: begin
        if (in_fire) begin
          state_d = MfaRead;
        end
      end
      MfaRead: begin
        state_d = MfaLoad;
      end
      MfaLoad: begin
        if (in_q.kind == KindClear || in_q.variance == '0) begin
          state_d = MfaWrite;
        end else begin
          state_d = MfaMulA;
          op_d    = in_q.nonzero ? OpInfo : OpYre;
        end
      end
      MfaMulA: begin
        state_d = MfaMulB;
      end
      MfaMulB: begin
        state_d = MfaSum;
      end
      MfaSum: begin
        state_d = MfaDiv;
      end
      MfaDiv: begin
        if (div_cnt_q == StepW'(QuoW - 1)) begin
          state_d = MfaAcc;
        end
      end
      MfaAcc: begin
        case (op_q)
          OpInfo: begin
            op_d    = OpYre;
            state_d = MfaMulA;
          end
          OpYre: begin
            op_d    = OpYim;
            state_d = MfaMulA;
          end
          default: begin
            state_d = MfaWrite;
          end
        endcase
      end
      MfaWrite: begin
        if (out_free) begin
          mem_we  = 1'b1;
          state_d = MfaIdle;
        end
      end
      default: begin
        state_d = MfaIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= MfaIdle;
      op_q         <= OpInfo;
      gate_count_q <= CountW'(MaxGates);
      counter_q    <= '0;
      fill_q       <= '0;
      out_valid_q  <= 1'b0;
      div_cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      if (cfg_we_i) begin
        gate_count_q <= cfg_data_i;
      end
      if (in_fire) begin
        counter_q <= (idx_inc >= gc_eff) ? '0 : idx_inc[GateW-1:0];
      end
      if (mem_we && idx_q_inc > fill_q) begin
        fill_q <= idx_q_inc;
      end
      if (mem_we) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == MfaDiv) begin
        div_cnt_q <= div_cnt_q + StepW'(1);
      end else begin
        div_cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q   <= in_word_i;
      idx_q  <= idx_sel;
      last_q <= ({1'b0, idx_sel} == gc_eff - CountW'(1));
    end
    if (state_q == MfaLoad) begin
      err_q <= (in_q.kind == KindAccum) && (in_q.variance == '0);
      if (in_q.kind == KindClear || !rd_valid) begin
        info_q <= '0;
        yre_q  <= '0;
        yim_q  <= '0;
      end else begin
        info_q <= rd_q[3*AccW-1:2*AccW];
        yre_q  <= rd_q[2*AccW-1:AccW];
        yim_q  <= rd_q[AccW-1:0];
      end
    end
    if (state_q == MfaMulA || state_q == MfaMulB) begin
      prod_q <= mul_p;
    end
    if (state_q == MfaMulB) begin
      first_q <= prod_q;
    end
    if (state_q == MfaSum) begin
      div_rem_q <= '0;
      div_quo_q <= mag_w[QuoW-1:0];
      div_neg_q <= sum_w[SumW-1];
    end else if (state_q == MfaDiv) begin
      div_rem_q <= div_ge ? RemW'(div_sh - {1'b0, in_q.variance}) : div_sh;
      div_quo_q <= {div_quo_q[QuoW-2:0], div_ge};
    end
    if (state_q == MfaAcc) begin
      case (op_q)
        OpInfo:  info_q <= acc_sat;
        OpYre:   yre_q  <= acc_sat;
        default: yim_q  <= acc_sat;
      endcase
    end
    if (mem_we) begin
      out_q.gate_index  <= idx_q;
      out_q.info_sum    <= info_q[InfoW-1:0];
      out_q.y_re        <= yre_q;
      out_q.y_im        <= yim_q;
      out_q.last_of_row <= last_q;
      out_q.div_error   <= err_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[idx_q] <= {info_q, yre_q, yim_q};
    end
    rd_q <= mem[idx_q];
  end

endmodule
